FILE: rtl/cfsd_pkg.sv
// ============================================================================
// cfsd_pkg - shared types and constants of the CAN frame serial deframer
// Frame record, request bundle to the output stage and the fixed protocol
// constants of the serial CAN framing.
// ============================================================================
package cfsd_pkg;

    // Framing marks and info byte layout
    localparam logic [7:0] START_MARK     = 8'hAA;
    localparam logic [7:0] END_MARK       = 8'h55;
    localparam logic [7:0] INFO_TYPE_MASK = 8'hC0;
    localparam int         EXT_BIT        = 5;
    localparam int         REM_BIT        = 4;
    localparam logic [3:0] DLC_MAX        = 4'd8;

    // Frame geometry, in bytes
    localparam logic [4:0] MIN_FILL   = 5'd5;
    localparam logic [4:0] HDR_LEN    = 5'd3;   // start, info, end
    localparam logic [4:0] ID_OFF     = 5'd2;   // first id byte
    localparam logic [4:0] STD_ID_LEN = 5'd2;
    localparam logic [4:0] EXT_ID_LEN = 5'd4;
    localparam logic [4:0] LEN_ONE    = 5'd1;

    // Frames per received byte
    localparam logic [1:0] MAX_RESULTS = 2'd3;

    // Output stream widths
    localparam int TDATA_W = 104;
    localparam int TUSER_W = 2;

    typedef struct packed {
        logic [31:0] frame_id;
        logic        is_extended;
        logic        is_remote;
        logic [3:0]  data_length;
        logic [63:0] payload;
        logic        last_of_run;
    } t_frame;

    // Request from the controller to the output register
    typedef struct packed {
        logic   valid;
        t_frame frame;
    } t_push;

endpackage

FILE: rtl/cfsd_ram.sv
// ============================================================================
// cfsd_ram - byte buffer storage
// Single write port, single read port, read data registered.
// ============================================================================
module cfsd_ram #(
    parameter int BUFFER_DEPTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_we,
    input  logic [$clog2(BUFFER_DEPTH)-1:0] i_waddr,
    input  logic [7:0]                      i_wdata,
    input  logic                            i_re,
    input  logic [$clog2(BUFFER_DEPTH)-1:0] i_raddr,
    output logic [7:0]                      o_rdata
);

    logic [7:0] r_mem [BUFFER_DEPTH];
    logic [7:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/cfsd_out.sv
// ============================================================================
// cfsd_out - output register stage
// Holds one finished frame for the downstream stream and packs it.
// ============================================================================
module cfsd_out (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  cfsd_pkg::t_push                i_push,
    output logic                           o_free,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [cfsd_pkg::TDATA_W-1:0]   o_m_tdata,
    output logic [cfsd_pkg::TUSER_W-1:0]   o_m_tuser,
    output logic                           o_m_tlast
);
    import cfsd_pkg::*;

    logic   r_valid;
    t_frame r_frame;

    // Slot can take a request when empty or being drained this cycle
    assign o_free = !r_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push.valid) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_frame <= i_push.frame;
        end
    end

    // tdata: frame_id, data_length, payload, zero fill
    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {4'b0, r_frame.payload, r_frame.data_length, r_frame.frame_id};
    assign o_m_tuser  = {r_frame.is_remote, r_frame.is_extended};
    assign o_m_tlast  = r_frame.last_of_run;

endmodule

FILE: rtl/cfsd_ctrl.sv
// ============================================================================
// cfsd_ctrl - deframing sequencer
// Keeps the byte buffer as a circular queue (head and fill count), scans it
// through the buffer's read port and assembles frames byte by byte.
// ============================================================================
module cfsd_ctrl #(
    parameter int BUFFER_DEPTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [7:0]                      i_s_tdata,
    output logic                            o_we,
    output logic [$clog2(BUFFER_DEPTH)-1:0] o_waddr,
    output logic [7:0]                      o_wdata,
    output logic                            o_re,
    output logic [$clog2(BUFFER_DEPTH)-1:0] o_raddr,
    input  logic [7:0]                      i_rdata,
    output cfsd_pkg::t_push                 o_push,
    input  logic                            i_out_free
);
    import cfsd_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam logic [AW:0]   DEPTH_W = (AW+1)'(BUFFER_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);
    localparam logic [CW-1:0] FILL_ONE = CW'(1);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SCAN_RD  = 4'd1;
    localparam logic [3:0] S_SCAN_CHK = 4'd2;
    localparam logic [3:0] S_INFO     = 4'd3;
    localparam logic [3:0] S_PAD      = 4'd4;
    localparam logic [3:0] S_PLAIN    = 4'd5;
    localparam logic [3:0] S_ASM      = 4'd6;
    localparam logic [3:0] S_EMIT     = 4'd7;
    localparam logic [3:0] S_FLUSH    = 4'd8;

    // Circular address: base plus offset, offset below the depth
    function automatic logic [AW-1:0] f_wrap(input logic [AW-1:0] base,
                                              input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= DEPTH_W) begin
            sum = sum - DEPTH_W;
        end
        return sum[AW-1:0];
    endfunction

    logic [3:0]    r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_fill, n_fill;
    logic [1:0]    r_nres, n_nres;
    logic          r_rd_vld, n_rd_vld;
    logic          r_pend_valid, n_pend_valid;
    t_frame        r_pend, n_pend;
    logic          r_ext, n_ext;
    logic          r_rem, n_rem;
    logic [3:0]    r_dlc, n_dlc;
    logic [4:0]    r_plain, n_plain;
    logic [4:0]    r_pad, n_pad;
    logic [4:0]    r_total, n_total;
    logic [4:0]    r_k, n_k;
    logic [4:0]    r_cap_off, n_cap_off;
    logic [31:0]   r_id, n_id;
    logic [63:0]   r_pay, n_pay;

    logic          w_full;
    logic [AW-1:0] w_head_inc;
    logic [4:0]    w_rd_off;
    logic          w_info_ok;
    logic [4:0]    w_idlen;
    logic [4:0]    w_plain;
    logic [4:0]    w_pad;
    logic [4:0]    w_idx;
    logic [4:0]    w_idlen_r;
    logic [4:0]    w_pay_idx;

    assign w_full     = (r_fill == DEPTH_C);
    assign w_head_inc = f_wrap(r_head, AW'(1));

    // Write side: a new byte overwrites the oldest entry when full
    assign o_s_tready = (r_state == S_IDLE);
    assign o_we       = o_s_tready && i_s_tvalid;
    assign o_wdata    = i_s_tdata;
    assign o_waddr    = w_full ? r_head : f_wrap(r_head, r_fill[AW-1:0]);

    assign o_raddr    = f_wrap(r_head, AW'(w_rd_off));

    // Info byte decode on live read data
    assign w_info_ok = ((i_rdata & INFO_TYPE_MASK) == INFO_TYPE_MASK)
                       && (i_rdata[3:0] <= DLC_MAX);
    assign w_idlen   = i_rdata[EXT_BIT] ? EXT_ID_LEN : STD_ID_LEN;
    assign w_plain   = HDR_LEN + w_idlen + {1'b0, i_rdata[3:0]};
    assign w_pad     = w_plain + LEN_ONE;

    // Lane of a captured frame byte
    assign w_idx     = r_cap_off - ID_OFF;
    assign w_idlen_r = r_ext ? EXT_ID_LEN : STD_ID_LEN;
    assign w_pay_idx = w_idx - w_idlen_r;

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_fill       = r_fill;
        n_nres       = r_nres;
        n_rd_vld     = r_rd_vld;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_ext        = r_ext;
        n_rem        = r_rem;
        n_dlc        = r_dlc;
        n_plain      = r_plain;
        n_pad        = r_pad;
        n_total      = r_total;
        n_k          = r_k;
        n_cap_off    = r_cap_off;
        n_id         = r_id;
        n_pay        = r_pay;
        o_re         = 1'b0;
        w_rd_off     = '0;
        o_push.valid = 1'b0;
        o_push.frame = r_pend;

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    if (w_full) begin
                        n_head = w_head_inc;
                    end else begin
                        n_fill = r_fill + FILL_ONE;
                    end
                    n_nres  = '0;
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                if (r_fill == '0) begin
                    n_state = S_FLUSH;
                end else begin
                    o_re    = 1'b1;
                    n_state = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                if (i_rdata != START_MARK) begin
                    // skip one byte, fetch the next in the same cycle
                    n_head = w_head_inc;
                    n_fill = r_fill - FILL_ONE;
                    if (r_fill == FILL_ONE) begin
                        n_state = S_FLUSH;
                    end else begin
                        o_re     = 1'b1;
                        w_rd_off = LEN_ONE;
                    end
                end else if (r_fill < CW'(MIN_FILL)) begin
                    n_state = S_FLUSH;
                end else begin
                    o_re     = 1'b1;
                    w_rd_off = LEN_ONE;
                    n_state  = S_INFO;
                end
            end
            S_INFO: begin
                n_ext   = i_rdata[EXT_BIT];
                n_rem   = i_rdata[REM_BIT];
                n_dlc   = i_rdata[3:0];
                n_plain = w_plain;
                n_pad   = w_pad;
                if (!w_info_ok) begin
                    n_head  = w_head_inc;
                    n_fill  = r_fill - FILL_ONE;
                    n_state = S_FLUSH;
                end else if (r_fill >= CW'(w_pad)) begin
                    o_re     = 1'b1;
                    w_rd_off = w_pad - LEN_ONE;
                    n_state  = S_PAD;
                end else if (r_fill >= CW'(w_plain)) begin
                    o_re     = 1'b1;
                    w_rd_off = w_plain - LEN_ONE;
                    n_state  = S_PLAIN;
                end else begin
                    n_state = S_FLUSH;
                end
            end
            S_PAD: begin
                if (i_rdata == END_MARK) begin
                    n_total  = r_pad;
                    n_k      = ID_OFF;
                    n_rd_vld = 1'b0;
                    n_id     = '0;
                    n_pay    = '0;
                    n_state  = S_ASM;
                end else begin
                    // padded length fits, so the unpadded one does too
                    o_re     = 1'b1;
                    w_rd_off = r_plain - LEN_ONE;
                    n_state  = S_PLAIN;
                end
            end
            S_PLAIN: begin
                if (i_rdata == END_MARK) begin
                    n_total  = r_plain;
                    n_k      = ID_OFF;
                    n_rd_vld = 1'b0;
                    n_id     = '0;
                    n_pay    = '0;
                    n_state  = S_ASM;
                end else begin
                    if (r_fill > CW'(r_pad)) begin
                        n_head = w_head_inc;
                        n_fill = r_fill - FILL_ONE;
                    end
                    n_state = S_FLUSH;
                end
            end
            S_ASM: begin
                // capture the byte fetched last cycle
                if (r_rd_vld) begin
                    if (w_idx < w_idlen_r) begin
                        for (int j = 0; j < 4; j++) begin
                            if (w_idx[1:0] == 2'(j)) begin
                                n_id[j*8 +: 8] = i_rdata;
                            end
                        end
                    end else begin
                        for (int j = 0; j < 8; j++) begin
                            if (w_pay_idx[2:0] == 3'(j)) begin
                                n_pay[j*8 +: 8] = i_rdata;
                            end
                        end
                    end
                end
                // fetch id and data bytes, up to the last data byte
                if (r_k != (r_plain - LEN_ONE)) begin
                    o_re      = 1'b1;
                    w_rd_off  = r_k;
                    n_cap_off = r_k;
                    n_rd_vld  = 1'b1;
                    n_k       = r_k + LEN_ONE;
                end else begin
                    n_rd_vld = 1'b0;
                    if (!r_rd_vld) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                // older frame goes out, this one waits to learn if it is last
                if (!r_pend_valid || i_out_free) begin
                    o_push.valid = r_pend_valid;
                    n_pend_valid = 1'b1;
                    n_pend.frame_id    = r_id;
                    n_pend.is_extended = r_ext;
                    n_pend.is_remote   = r_rem;
                    n_pend.data_length = r_dlc;
                    n_pend.payload     = r_pay;
                    n_pend.last_of_run = 1'b0;
                    n_head = f_wrap(r_head, AW'(r_total));
                    n_fill = r_fill - CW'(r_total);
                    n_nres = r_nres + 2'd1;
                    if (r_nres == (MAX_RESULTS - 2'd1)) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_state = S_SCAN_RD;
                    end
                end
            end
            S_FLUSH: begin
                if (!r_pend_valid) begin
                    n_state = S_IDLE;
                end else if (i_out_free) begin
                    o_push.valid = 1'b1;
                    o_push.frame.last_of_run = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_head       <= '0;
            r_fill       <= '0;
            r_nres       <= '0;
            r_rd_vld     <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_fill       <= n_fill;
            r_nres       <= n_nres;
            r_rd_vld     <= n_rd_vld;
            r_pend_valid <= n_pend_valid;
        end
    end

    // Working registers of the current frame
    always_ff @(posedge i_clk) begin
        r_pend    <= n_pend;
        r_ext     <= n_ext;
        r_rem     <= n_rem;
        r_dlc     <= n_dlc;
        r_plain   <= n_plain;
        r_pad     <= n_pad;
        r_total   <= n_total;
        r_k       <= n_k;
        r_cap_off <= n_cap_off;
        r_id      <= n_id;
        r_pay     <= n_pay;
    end

    // Checks
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= DEPTH_C)
        else $error("fill count beyond buffer depth");

    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_head} < DEPTH_W)
        else $error("head pointer outside buffer");

    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.valid |-> i_out_free)
        else $error("request to a busy output register");

    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_valid)
        else $error("frame left pending while taking a new byte");

    a_frame_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ASM) |-> (r_fill >= CW'(r_total)))
        else $error("frame longer than buffered bytes");

endmodule

FILE: rtl/can_frame_serial_deframer_unit.sv
// ============================================================================
// can_frame_serial_deframer_unit - CAN frame deframer for a serial byte link
// Buffers received bytes and extracts start/info/id/data/end framed CAN
// frames, up to three frames per received byte.
// ============================================================================
// One received byte is taken per request; the unit then works on it alone
// until every frame it releases has been handed to the output register.
// For each frame the sequencer skips bytes until a start mark, checks the
// info byte, looks for the end mark at the padded length and then at the
// unpadded one, and fetches the id and data bytes; a frame also waits
// while the output register is still full. The sequencer reads the byte
// buffer through its single read port, one byte per cycle at most. The
// buffer needs no clearing after reset: only entries below the fill count
// are ever read. The last frame of a byte's run is marked with tlast; it
// is held until the unit knows no further frame follows, so a frame leaves
// one extraction attempt late.
// ============================================================================
module can_frame_serial_deframer_unit #(
    parameter int BUFFER_DEPTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [7:0]                    i_s_tdata,   // [7:0] rx_byte
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [31:0] frame_id, [35:32] data_length, [99:36] payload, [103:100] zero
    output logic [cfsd_pkg::TDATA_W-1:0]  o_m_tdata,
    // [0] is_extended, [1] is_remote
    output logic [cfsd_pkg::TUSER_W-1:0]  o_m_tuser,
    output logic                          o_m_tlast    // last_of_run
);
    import cfsd_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);

    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [7:0]    w_wdata;
    logic          w_re;
    logic [AW-1:0] w_raddr;
    logic [7:0]    w_rdata;
    t_push         w_push;
    logic          w_out_free;

    cfsd_ram #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    cfsd_ctrl #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_we       (w_we),
        .o_waddr    (w_waddr),
        .o_wdata    (w_wdata),
        .o_re       (w_re),
        .o_raddr    (w_raddr),
        .i_rdata    (w_rdata),
        .o_push     (w_push),
        .i_out_free (w_out_free)
    );

    cfsd_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .o_free     (w_out_free),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule
